### src/eikonal_fast_sweep_grid_defines.svh
// Assertion macros for the eikonal sweep grid.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef EIKONAL_FAST_SWEEP_GRID_DEFINES_SVH
`define EIKONAL_FAST_SWEEP_GRID_DEFINES_SVH

// implication in the same cycle
`define EFS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define EFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/efsg_pkg.sv
// Types and constants for the eikonal sweep grid.
// No dependencies.
package efsg_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  localparam logic CFG_GRID_SIZE    = 1'b0;
  localparam logic CFG_GRID_SPACING = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_R0, S_R1, S_R2, S_R3, S_R4, S_BR,
    S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_ROOT, S_FIN, S_NEXT
  } state_e;

  // {rows outer, outer reversed, inner reversed}
  localparam logic [2:0] SWEEP_PLAN [8] = '{
    3'b100, 3'b110, 3'b101, 3'b111, 3'b000, 3'b001, 3'b010, 3'b011
  };

  localparam logic [31:0] Q_MAX = 32'hFFFF_FFFF;

  function automatic logic [32:0] clamp_q(input logic [50:0] v);
    if (v > {19'd0, Q_MAX}) begin
      return {1'b1, Q_MAX};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

### src/eikonal_fast_sweep_grid.sv
// Eikonal solver, fast sweeping on an n-by-n grid; a read passes S_READ to a registered
// result. A run takes 8*n*n cell visits: a fixed cell S_R0, S_R1, S_NEXT; a far branch
// S_R0 to S_R4, S_BR, S_NEXT; a root adds S_SQ1 to S_SQ4 on the shared 32x32 multiplier,
// S_ROOT for the two-bit-a-step square root, S_FIN. Results are strobed for one cycle;
// an item is taken only while busy is low. Reset clears control and sat flag; grid stores
// undefined until loaded. Depends on efsg_pkg and eikonal_fast_sweep_grid_defines.svh.
module eikonal_fast_sweep_grid #(
  parameter int GRID_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [11:0] cell_index_i,
  input  logic [31:0] dist_in_i,
  input  logic [31:0] speed_in_i,
  input  logic        fixed_in_i,
  output logic        out_valid_o,
  output logic [31:0] dist_out_o,
  output logic        run_done_o,
  output logic        saturated_o
);
  import efsg_pkg::*;
  `include "eikonal_fast_sweep_grid_defines.svh"

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_MAX);
  localparam int NW    = $clog2(GRID_MAX + 1);

  logic [31:0] dist_mem  [CELLS];
  logic [31:0] speed_mem [CELLS];
  logic        fix_mem   [CELLS];

  state_e state_q, state_d;
  logic [6:0]  gsize_q;
  logic [31:0] dx_q;
  logic [NW-1:0] n_q, n_clamp;
  logic [2:0]  s_q;
  logic [CW-1:0] p_q, q_q;
  logic [5:0]  cnt_q;
  logic        sat_q, rd_ok_q;
  logic        out_valid_q, run_done_q;
  logic [31:0] dist_out_q;

  logic [31:0] rd_dist_q, rd_speed_q, spd_q, a_q, b_q;
  logic        rd_fix_q;
  logic [63:0] prod_q;
  logic [47:0] h_q;
  logic [127:0] acc_q;
  logic [49:0] root_q;
  logic [52:0] rem_q;

  logic [AW-1:0] rd_addr, aux_addr, here, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;
  logic [31:0] mul_a, mul_b;
  logic [CW-1:0] n_m1, o, in_i, r, c;
  logic [2:0]  plan;
  logic [31:0] d, lo_ab;
  logic        far, last;
  logic [52:0] rem_sh, trial;
  logic        ge;
  logic [32:0] far_res, root_res;
  logic        accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    if (gsize_q < 7'd2) begin
      n_clamp = NW'(2);
    end else if (int'(gsize_q) > GRID_MAX) begin
      n_clamp = NW'(GRID_MAX);
    end else begin
      n_clamp = NW'(gsize_q);
    end
  end

  assign plan = SWEEP_PLAN[s_q];
  assign n_m1 = CW'(n_q - NW'(1));
  assign o    = plan[1] ? n_m1 - p_q : p_q;
  assign in_i = plan[0] ? n_m1 - q_q : q_q;
  assign r    = plan[2] ? o : in_i;
  assign c    = plan[2] ? in_i : o;
  assign here = AW'(r) + AW'(n_q) * AW'(c);
  assign last = (s_q == 3'd7) && (p_q == n_m1) && (q_q == n_m1);

  assign d     = (a_q > b_q) ? a_q - b_q : b_q - a_q;
  assign lo_ab = (a_q < b_q) ? a_q : b_q;
  assign far   = {16'd0, d} > h_q;
  assign far_res  = clamp_q({19'd0, lo_ab} + {3'd0, h_q});
  assign root_res = clamp_q((51'(a_q) + 51'(b_q) + 51'(root_q)) >> 1);

  assign rem_sh = {rem_q[50:0], acc_q[127:126]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    state_d  = state_q;
    rd_addr  = AW'(cell_index_i);
    aux_addr = here;
    mul_a    = spd_q;
    mul_b    = dx_q;
    wr_en    = 1'b0;
    wr_addr  = here;
    wr_data  = far_res[31:0];
    case (state_q)
      S_IDLE: begin
        aux_addr = AW'(cell_index_i);
        if (accept) begin
          case (kind_i)
            KIND_RUN:  state_d = S_R0;
            KIND_READ: state_d = S_READ;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_READ: state_d = S_IDLE;
      S_R0: begin
        rd_addr = (r == '0) ? here + AW'(1) : here - AW'(1);
        state_d = S_R1;
      end
      S_R1: begin
        rd_addr = (r == n_m1) ? here - AW'(1) : here + AW'(1);
        state_d = rd_fix_q ? S_NEXT : S_R2;
      end
      S_R2: begin
        rd_addr = (c == '0) ? here + AW'(n_q) : here - AW'(n_q);
        state_d = S_R3;
      end
      S_R3: begin
        rd_addr = (c == n_m1) ? here - AW'(n_q) : here + AW'(n_q);
        state_d = S_R4;
      end
      S_R4: state_d = S_BR;
      S_BR: begin
        mul_a = h_q[31:0];
        mul_b = h_q[31:0];
        if (far) begin
          wr_en   = 1'b1;
          state_d = S_NEXT;
        end else begin
          state_d = S_SQ1;
        end
      end
      S_SQ1: begin
        mul_a   = {16'd0, h_q[47:32]};
        mul_b   = h_q[31:0];
        state_d = S_SQ2;
      end
      S_SQ2: begin
        mul_a   = {16'd0, h_q[47:32]};
        mul_b   = {16'd0, h_q[47:32]};
        state_d = S_SQ3;
      end
      S_SQ3: begin
        mul_a   = d;
        mul_b   = d;
        state_d = S_SQ4;
      end
      S_SQ4: state_d = S_ROOT;
      S_ROOT: state_d = (cnt_q == 6'd63) ? S_FIN : S_ROOT;
      S_FIN: begin
        wr_en   = 1'b1;
        wr_data = root_res[31:0];
        state_d = S_NEXT;
      end
      S_NEXT: state_d = last ? S_IDLE : S_R0;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && kind_i == KIND_LOAD &&
        {20'd0, cell_index_i} < 32'(CELLS)) begin
      dist_mem[AW'(cell_index_i)]  <= dist_in_i;
      speed_mem[AW'(cell_index_i)] <= speed_in_i;
      fix_mem[AW'(cell_index_i)]   <= fixed_in_i;
    end else if (wr_en) begin
      dist_mem[wr_addr] <= wr_data;
    end
    rd_dist_q  <= dist_mem[rd_addr];
    rd_speed_q <= speed_mem[aux_addr];
    rd_fix_q   <= fix_mem[aux_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: rd_ok_q <= {20'd0, cell_index_i} < 32'(CELLS);
      S_R1: begin
        a_q   <= rd_dist_q;
        spd_q <= rd_speed_q;
      end
      S_R2: a_q <= (rd_dist_q < a_q) ? rd_dist_q : a_q;
      S_R3: begin
        b_q <= rd_dist_q;
        h_q <= prod_q[63:16];
      end
      S_R4: b_q <= (rd_dist_q < b_q) ? rd_dist_q : b_q;
      S_SQ1: acc_q <= {63'd0, prod_q, 1'b0};
      S_SQ2: acc_q <= acc_q + {30'd0, prod_q, 34'd0};
      S_SQ3: acc_q <= acc_q + {prod_q[62:0], 65'd0};
      S_SQ4: begin
        acc_q  <= acc_q - {64'd0, prod_q};
        root_q <= '0;
        rem_q  <= '0;
      end
      S_ROOT: begin
        acc_q  <= {acc_q[125:0], 2'b00};
        rem_q  <= ge ? rem_sh - trial : rem_sh;
        root_q <= {root_q[48:0], ge};
      end
      default: ;
    endcase
  end

  // control counters, config, results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q     <= 7'd64;
      dx_q        <= 32'd65536;
      n_q         <= NW'(2);
      s_q         <= '0;
      p_q         <= '0;
      q_q         <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      run_done_q  <= 1'b0;
      dist_out_q  <= '0;
    end else begin
      out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_GRID_SIZE) begin
          gsize_q <= cfg_data_i[6:0];
        end else begin
          dx_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (accept && kind_i == KIND_RUN) begin
            n_q   <= n_clamp;
            s_q   <= '0;
            p_q   <= '0;
            q_q   <= '0;
            sat_q <= 1'b0;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          run_done_q  <= 1'b0;
          dist_out_q  <= rd_ok_q ? rd_dist_q : 32'd0;
        end
        S_BR: if (far) sat_q <= sat_q | far_res[32];
        S_SQ4: cnt_q <= '0;
        S_ROOT: cnt_q <= cnt_q + 6'd1;
        S_FIN: sat_q <= sat_q | root_res[32];
        S_NEXT: begin
          if (last) begin
            out_valid_q <= 1'b1;
            run_done_q  <= 1'b1;
            dist_out_q  <= '0;
          end else if (q_q == n_m1) begin
            q_q <= '0;
            if (p_q == n_m1) begin
              p_q <= '0;
              s_q <= s_q + 3'd1;
            end else begin
              p_q <= p_q + CW'(1);
            end
          end else begin
            q_q <= q_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign dist_out_o  = dist_out_q;
  assign run_done_o  = run_done_q;
  assign saturated_o = sat_q;

  `EFS_ASSERT_SAME(a_run_zero, clk_i, rst_ni, out_valid_o && run_done_o, dist_out_o == 32'd0, "run result carries nonzero distance")
  `EFS_ASSERT_NEXT(a_one_result, clk_i, rst_ni, out_valid_o, !out_valid_o, "results back to back")
  `EFS_ASSERT_NEXT(a_run_busy, clk_i, rst_ni, accept && kind_i == KIND_RUN, busy && !out_valid_o, "run did not start")
  `EFS_ASSERT_SAME(a_root_far, clk_i, rst_ni, state_q == S_SQ1, !$past(far), "root path taken on far branch")

endmodule

### bench/tb_eikonal_fast_sweep_grid.sv
// Self-checking bench for eikonal_fast_sweep_grid: directed table, then random phases
// of grid loads, reads and sweep runs, results checked against an in-bench sweep predictor or typed table values.
// Depends on efsg_pkg and the RTL of the block only.
module tb_eikonal_fast_sweep_grid;
  timeunit 1ns;
  timeprecision 1ps;
  import efsg_pkg::*;

  localparam int CELLS = 4096;
  localparam int ITEM_GOAL = 1650;
  localparam int STALL_LIMIT = 600000;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [31:0] dval;
    logic        done;
    logic        sat;
  } cell_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] idx;
    logic [31:0] dval;
    logic [31:0] speed;
    logic        fixed;
    logic        typed;
    logic [31:0] e_dist;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = '0;
  logic [11:0] cell_index_i = '0;
  logic [31:0] dist_in_i = '0;
  logic [31:0] speed_in_i = '0;
  logic        fixed_in_i = 1'b0;
  logic        out_valid_o;
  logic [31:0] dist_out_o;
  logic        run_done_o;
  logic        saturated_o;

  eikonal_fast_sweep_grid dut (.*);

  logic [6:0]  grid_n_reg = 7'd64;
  logic [31:0] dx_reg = 32'h0001_0000;
  logic [31:0] dist_mem [CELLS];
  logic [31:0] speed_mem [CELLS];
  logic        fixed_mem [CELLS];
  bit          written [CELLS];
  logic        sat_seen = 1'b0;
  cell_result_t pending_q [$];
  int errors = 0;
  int items = 0;
  int stall_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt128(input logic [127:0] x);
    logic [63:0]  root;
    logic [129:0] rem;
    logic [129:0] trial;
    root = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | x[2*k +: 2];
      trial = ({66'd0, root} << 2) | 130'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] clamp_dist(input logic [63:0] v);
    if (v > 64'h0000_0000_FFFF_FFFF) begin
      sat_seen = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic void relax_cell(input int r, input int c, input int n);
    int here;
    logic [31:0] a, b, d, lo_ab;
    logic [63:0] h, s;
    logic [127:0] rad;
    here = r + n * c;
    if (r == 0) a = dist_mem[here + 1];
    else if (r == n - 1) a = dist_mem[here - 1];
    else a = (dist_mem[here + 1] < dist_mem[here - 1]) ? dist_mem[here + 1] : dist_mem[here - 1];
    if (c == 0) b = dist_mem[here + n];
    else if (c == n - 1) b = dist_mem[here - n];
    else b = (dist_mem[here + n] < dist_mem[here - n]) ? dist_mem[here + n] : dist_mem[here - n];
    h = ({32'd0, speed_mem[here]} * {32'd0, dx_reg}) >> 16;
    d = (a > b) ? a - b : b - a;
    lo_ab = (a < b) ? a : b;
    if ({32'd0, d} > h) begin
      dist_mem[here] = clamp_dist({32'd0, lo_ab} + h);
    end else begin
      rad = (({64'd0, h} * {64'd0, h}) << 1) - ({96'd0, d} * {96'd0, d});
      s = isqrt128(rad);
      dist_mem[here] = clamp_dist(({32'd0, a} + {32'd0, b} + s) >> 1);
    end
  endfunction

  function automatic void sweep_grid();
    int n, o, in_i, r, c;
    n = grid_n_reg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    sat_seen = 1'b0;
    for (int sw = 0; sw < 8; sw++) begin
      for (int p = 0; p < n; p++) begin
        o = SWEEP_PLAN[sw][1] ? n - 1 - p : p;
        for (int q = 0; q < n; q++) begin
          in_i = SWEEP_PLAN[sw][0] ? n - 1 - q : q;
          r = SWEEP_PLAN[sw][2] ? o : in_i;
          c = SWEEP_PLAN[sw][2] ? in_i : o;
          if (!fixed_mem[r + n * c]) relax_cell(r, c, n);
        end
      end
    end
  endfunction

  function automatic void predict_item(input stim_row_t it);
    cell_result_t res;
    res = '0;
    case (it.kind)
      KIND_LOAD: begin
        dist_mem[it.idx] = it.dval;
        speed_mem[it.idx] = it.speed;
        fixed_mem[it.idx] = it.fixed;
        written[it.idx] = 1'b1;
      end
      KIND_RUN: begin
        sweep_grid();
        res.done = 1'b1;
        res.sat = sat_seen;
        pending_q.push_back(res);
      end
      KIND_READ: begin
        res.dval = it.typed ? it.e_dist : dist_mem[it.idx];
        res.sat = sat_seen;
        pending_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input stim_row_t it, input int idle_pct);
    start <= 1'b1;
    kind_i <= it.kind;
    cell_index_i <= it.idx;
    dist_in_i <= it.dval;
    speed_in_i <= it.speed;
    fixed_in_i <= it.fixed;
    do @(posedge clk_i); while (busy);
    predict_item(it);
    items++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GRID_SIZE) grid_n_reg = data[6:0];
    else dx_reg = data;
  endtask

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0003_0000);
    endcase
  endfunction

  function automatic int idle_now();
    if (items < 550) return 8;
    if (items < 1100) return 68;
    return 0;
  endfunction

  function automatic stim_row_t make_load(input int idx, input logic fx);
    stim_row_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.idx = 12'(idx);
    it.dval = pick_dist();
    it.speed = pick_speed();
    it.fixed = fx;
    return it;
  endfunction

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && out_valid_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result dist=%h done=%b sat=%b", $time,
                 dist_out_o, run_done_o, saturated_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (dist_out_o !== want.dval) begin
          $display("%0t dist_out expected %h actual %h", $time, want.dval, dist_out_o);
          errors++;
        end
        if (run_done_o !== want.done) begin
          $display("%0t run_done expected %b actual %b", $time, want.done, run_done_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t saturated expected %b actual %b", $time, want.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || cfg_we_i || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [16];
    stim_row_t it;
    int n, cells, burst, sz_pick;
    dir_rows[0]  = '{KIND_LOAD, 12'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b0, 32'd0};
    dir_rows[1]  = '{KIND_LOAD, 12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0};
    dir_rows[2]  = '{KIND_LOAD, 12'd2, 32'd1, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[3]  = '{KIND_LOAD, 12'd3, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 32'd0};
    dir_rows[4]  = '{KIND_READ, 12'd0, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0};
    dir_rows[5]  = '{KIND_READ, 12'd1, 32'd0, 32'd0, 1'b0, 1'b1, 32'hFFFF_FFFF};
    dir_rows[6]  = '{KIND_READ, 12'd2, 32'd0, 32'd0, 1'b0, 1'b1, 32'd1};
    dir_rows[7]  = '{KIND_LOAD, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0};
    dir_rows[8]  = '{KIND_READ, 12'd4095, 32'd0, 32'd0, 1'b0, 1'b1, 32'hFFFF_FFFF};
    dir_rows[9]  = '{KIND_BAD, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0};
    dir_rows[10] = '{KIND_RUN, 12'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[11] = '{KIND_READ, 12'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[12] = '{KIND_READ, 12'd1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[13] = '{KIND_READ, 12'd2, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[14] = '{KIND_READ, 12'd3, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    dir_rows[15] = '{KIND_READ, 12'd4095, 32'd0, 32'd0, 1'b0, 1'b1, 32'hFFFF_FFFF};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_GRID_SIZE, 32'd2);
    write_reg(CFG_GRID_SPACING, 32'h0001_0000);
    foreach (dir_rows[i]) send_item(dir_rows[i], 0);
    drain();

    while (items < ITEM_GOAL) begin
      sz_pick = $urandom_range(9);
      case (sz_pick)
        0: n = 0;
        1: n = 1;
        2, 3: n = 2;
        4, 5: n = 3;
        6, 7: n = 4;
        8: n = 6;
        default: n = 8;
      endcase
      write_reg(CFG_GRID_SIZE, {25'($urandom_range(0, 32'h01FF_FFFF)), 7'(n)});
      case ($urandom_range(4))
        0: write_reg(CFG_GRID_SPACING, 32'd1);
        1: write_reg(CFG_GRID_SPACING, 32'hFFFF_FFFF);
        2: write_reg(CFG_GRID_SPACING, 32'h0001_0000);
        3: write_reg(CFG_GRID_SPACING, $urandom_range(32'h100, 32'h4_0000));
        default: write_reg(CFG_GRID_SPACING, $urandom);
      endcase
      if (n < 2) n = 2;
      cells = n * n;
      for (int i = 0; i < cells; i++) send_item(make_load(i, $urandom_range(3) == 0), idle_now());
      burst = $urandom_range(50, 100);
      for (int j = 0; j < burst; j++) begin
        it = '0;
        case ($urandom_range(99)) inside
          [0:39]: it = make_load($urandom_range(0, cells - 1), $urandom_range(3) == 0);
          [40:44]: it = make_load($urandom_range(0, CELLS - 1), $urandom_range(1));
          [45:91]: begin
            it.kind = KIND_READ;
            it.idx = 12'($urandom_range(0, CELLS - 1));
            if (!written[it.idx]) it.idx = 12'(int'(it.idx) % cells);
          end
          [92:97]: it.kind = KIND_RUN;
          default: begin
            it = make_load($urandom_range(0, CELLS - 1), $urandom_range(1));
            it.kind = KIND_BAD;
          end
        endcase
        send_item(it, idle_now());
      end
      drain();
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### eikonal_fast_sweep_grid.f
+incdir+src
src/efsg_pkg.sv
src/eikonal_fast_sweep_grid.sv
bench/tb_eikonal_fast_sweep_grid.sv
